FILE: src/llpc_pkg.sv
`timescale 1ns / 1ps

package llpc_pkg;

    localparam int PAYLOAD_MAX_DEF = 256;

    localparam int BYTES_PER_NODE = 3;
    localparam int COLOR_SPAN = 6;
    localparam int CAP_IDX_W = $clog2(COLOR_SPAN);

    localparam int NODE_W = 4;
    localparam int LONG_W = 20;
    localparam int SHORT_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = LONG_W;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_LOST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_SLEEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF = 3'd4;

    localparam logic [NODE_W-1:0] NODE_ADDRESS_RST = 4'd0;
    localparam logic [LONG_W-1:0] STARTUP_TIMEOUT_RST = 20'd300000;
    localparam logic [SHORT_W-1:0] SIGNAL_LOST_RST = 16'd2000;
    localparam logic [LONG_W-1:0] LOST_SLEEP_RST = 20'd300000;
    localparam logic [SHORT_W-1:0] BLINK_HALF_RST = 16'd400;

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_ACTIVE = 2'd1;
    localparam logic [1:0] PH_LOST = 2'd2;
    localparam logic [1:0] PH_SLEEP = 2'd3;

    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_SHOW = 3'd1;
    localparam logic [2:0] ACT_SHORT = 3'd2;
    localparam logic [2:0] ACT_ORANGE = 3'd3;
    localparam logic [2:0] ACT_CLEAR = 3'd4;
    localparam logic [2:0] ACT_SLEEP = 3'd5;

    localparam logic [7:0] ORANGE_RED = 8'd255;
    localparam logic [7:0] ORANGE_GREEN = 8'd80;
    localparam logic [7:0] ORANGE_BLUE = 8'd0;

    typedef struct packed {
        logic [NODE_W-1:0]  node_address;
        logic [LONG_W-1:0]  startup_timeout_ms;
        logic [SHORT_W-1:0] signal_lost_ms;
        logic [LONG_W-1:0]  lost_sleep_ms;
        logic [SHORT_W-1:0] blink_half_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic [1:0] power_phase;
    } result_t;

endpackage

FILE: src/llpc_item_if.sv
`timescale 1ns / 1ps

interface llpc_item_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] payload_byte;
    logic       last_byte;
    logic       charging;

    modport source (output valid, output mode, output payload_byte, output last_byte,
                    output charging, input ready);
    modport sink (input valid, input mode, input payload_byte, input last_byte,
                  input charging, output ready);
endinterface

FILE: src/llpc_result_if.sv
`timescale 1ns / 1ps

interface llpc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic [1:0] power_phase;

    modport source (output valid, output action, output red_first, output green_first,
                    output blue_first, output red_second, output green_second,
                    output blue_second, output power_phase, input ready);
    modport sink (input valid, input action, input red_first, input green_first,
                  input blue_first, input red_second, input green_second,
                  input blue_second, input power_phase, output ready);
endinterface

FILE: src/llpc_cfg.sv
`timescale 1ns / 1ps

module llpc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [llpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [llpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output llpc_pkg::cfg_t                      cfg
);

    llpc_pkg::cfg_t cfg_reg;
    llpc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                llpc_pkg::CFG_NODE_ADDRESS:
                    cfg_next.node_address = cfg_data[llpc_pkg::NODE_W-1:0];
                llpc_pkg::CFG_STARTUP_TIMEOUT:
                    cfg_next.startup_timeout_ms = cfg_data[llpc_pkg::LONG_W-1:0];
                llpc_pkg::CFG_SIGNAL_LOST:
                    cfg_next.signal_lost_ms = cfg_data[llpc_pkg::SHORT_W-1:0];
                llpc_pkg::CFG_LOST_SLEEP:
                    cfg_next.lost_sleep_ms = cfg_data[llpc_pkg::LONG_W-1:0];
                llpc_pkg::CFG_BLINK_HALF:
                    cfg_next.blink_half_ms = cfg_data[llpc_pkg::SHORT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_address <= llpc_pkg::NODE_ADDRESS_RST;
            cfg_reg.startup_timeout_ms <= llpc_pkg::STARTUP_TIMEOUT_RST;
            cfg_reg.signal_lost_ms <= llpc_pkg::SIGNAL_LOST_RST;
            cfg_reg.lost_sleep_ms <= llpc_pkg::LOST_SLEEP_RST;
            cfg_reg.blink_half_ms <= llpc_pkg::BLINK_HALF_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/llpc_engine.sv
`timescale 1ns / 1ps

module llpc_engine #(
    parameter int PAYLOAD_MAX = llpc_pkg::PAYLOAD_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  llpc_pkg::cfg_t    cfg,
    input  logic              fire,
    input  logic              mode,
    input  logic [7:0]        payload_byte,
    input  logic              last_byte,
    input  logic              charging,
    output llpc_pkg::result_t res
);

    localparam int POS_W = $clog2(PAYLOAD_MAX + 1);
    localparam int BASE_W = 6;
    localparam int CW = ((POS_W > BASE_W) ? POS_W : BASE_W) + 1;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(PAYLOAD_MAX);
    localparam logic [CW-1:0] SPAN = CW'(llpc_pkg::COLOR_SPAN);
    localparam logic [CW-1:0] STRIDE = CW'(llpc_pkg::BYTES_PER_NODE);

    logic [1:0]                   phase_reg;
    logic [1:0]                   phase_next;
    logic [llpc_pkg::LONG_W-1:0]  phase_elapsed_reg;
    logic [llpc_pkg::LONG_W-1:0]  phase_elapsed_next;
    logic [llpc_pkg::LONG_W-1:0]  data_elapsed_reg;
    logic [llpc_pkg::LONG_W-1:0]  data_elapsed_next;
    logic [llpc_pkg::SHORT_W-1:0] blink_elapsed_reg;
    logic [llpc_pkg::SHORT_W-1:0] blink_elapsed_next;
    logic                         blink_lit_reg;
    logic                         blink_lit_next;
    logic [POS_W-1:0]             pos_reg;
    logic [POS_W-1:0]             pos_next;
    logic [7:0]                   cap_reg [llpc_pkg::COLOR_SPAN];

    logic [CW-1:0]                   base;
    logic [CW-1:0]                   pos_ext;
    logic [CW-1:0]                   offset;
    logic [CW-1:0]                   len_ext;
    logic [POS_W-1:0]                pos_inc;
    logic                            below_max;
    logic                            cap_we;
    logic [llpc_pkg::CAP_IDX_W-1:0]  cap_idx;
    logic [7:0]                      color [llpc_pkg::COLOR_SPAN];
    logic [llpc_pkg::LONG_W-1:0]     pe_inc;
    logic [llpc_pkg::LONG_W-1:0]     de_inc;
    logic [llpc_pkg::SHORT_W-1:0]    be_inc;

    assign base = CW'(cfg.node_address) * STRIDE;
    assign pos_ext = CW'(pos_reg);
    assign offset = pos_ext - base;
    assign cap_idx = offset[llpc_pkg::CAP_IDX_W-1:0];
    assign below_max = pos_reg < POS_MAX;
    assign pos_inc = below_max ? pos_reg + 1'b1 : pos_reg;
    assign len_ext = CW'(pos_inc);

    assign pe_inc = (&phase_elapsed_reg) ? phase_elapsed_reg : phase_elapsed_reg + 1'b1;
    assign de_inc = (&data_elapsed_reg) ? data_elapsed_reg : data_elapsed_reg + 1'b1;
    assign be_inc = (&blink_elapsed_reg) ? blink_elapsed_reg : blink_elapsed_reg + 1'b1;

    // The byte being written this cycle is forwarded so a final color byte shows at once.
    always_comb
    begin
        for (int i = 0; i < llpc_pkg::COLOR_SPAN; i++)
        begin
            color[i] = (cap_we && cap_idx == llpc_pkg::CAP_IDX_W'(i)) ? payload_byte
                                                                       : cap_reg[i];
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        phase_elapsed_next = phase_elapsed_reg;
        data_elapsed_next = data_elapsed_reg;
        blink_elapsed_next = blink_elapsed_reg;
        blink_lit_next = blink_lit_reg;
        pos_next = pos_reg;
        cap_we = 1'b0;
        res = '0;
        res.action = llpc_pkg::ACT_NONE;

        if (phase_reg != llpc_pkg::PH_SLEEP)
        begin
            if (mode)
            begin
                cap_we = below_max && pos_ext >= base && pos_ext < base + SPAN;
                pos_next = pos_inc;
                if (last_byte)
                begin
                    pos_next = '0;
                    data_elapsed_next = '0;
                    if (phase_reg != llpc_pkg::PH_ACTIVE)
                    begin
                        phase_next = llpc_pkg::PH_ACTIVE;
                        phase_elapsed_next = '0;
                    end
                    if (len_ext >= base + SPAN)
                    begin
                        res.action = llpc_pkg::ACT_SHOW;
                        res.red_first = color[0];
                        res.green_first = color[1];
                        res.blue_first = color[2];
                        res.red_second = color[3];
                        res.green_second = color[4];
                        res.blue_second = color[5];
                    end
                    else
                    begin
                        res.action = llpc_pkg::ACT_SHORT;
                    end
                end
            end
            else
            begin
                phase_elapsed_next = pe_inc;
                data_elapsed_next = de_inc;
                blink_elapsed_next = be_inc;
                if (!charging)
                begin
                    case (phase_reg)
                        llpc_pkg::PH_WAIT:
                        begin
                            if (pe_inc >= cfg.startup_timeout_ms)
                            begin
                                phase_next = llpc_pkg::PH_SLEEP;
                                res.action = llpc_pkg::ACT_SLEEP;
                            end
                        end
                        llpc_pkg::PH_ACTIVE:
                        begin
                            if (de_inc >= llpc_pkg::LONG_W'(cfg.signal_lost_ms))
                            begin
                                phase_next = llpc_pkg::PH_LOST;
                                phase_elapsed_next = '0;
                                blink_elapsed_next = '0;
                                blink_lit_next = 1'b0;
                            end
                        end
                        llpc_pkg::PH_LOST:
                        begin
                            if (pe_inc >= cfg.lost_sleep_ms)
                            begin
                                phase_next = llpc_pkg::PH_SLEEP;
                                res.action = llpc_pkg::ACT_SLEEP;
                            end
                            else if (be_inc >= cfg.blink_half_ms)
                            begin
                                blink_elapsed_next = '0;
                                blink_lit_next = !blink_lit_reg;
                                if (!blink_lit_reg)
                                begin
                                    res.action = llpc_pkg::ACT_ORANGE;
                                    res.red_first = llpc_pkg::ORANGE_RED;
                                    res.green_first = llpc_pkg::ORANGE_GREEN;
                                    res.blue_first = llpc_pkg::ORANGE_BLUE;
                                    res.red_second = llpc_pkg::ORANGE_RED;
                                    res.green_second = llpc_pkg::ORANGE_GREEN;
                                    res.blue_second = llpc_pkg::ORANGE_BLUE;
                                end
                                else
                                begin
                                    res.action = llpc_pkg::ACT_CLEAR;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
        res.power_phase = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= llpc_pkg::PH_WAIT;
            phase_elapsed_reg <= '0;
            data_elapsed_reg <= '0;
            blink_elapsed_reg <= '0;
            blink_lit_reg <= 1'b0;
            pos_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            phase_elapsed_reg <= phase_elapsed_next;
            data_elapsed_reg <= data_elapsed_next;
            blink_elapsed_reg <= blink_elapsed_next;
            blink_lit_reg <= blink_lit_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && cap_we)
        begin
            cap_reg[cap_idx] <= payload_byte;
        end
    end

endmodule

FILE: src/link_loss_power_controller_top.sv
`timescale 1ns / 1ps

// Channel  | Role   | Payload
// item     | sink   | mode, payload_byte, last_byte, charging
// result   | source | action, six color bytes, power_phase
// cfg      | write  | cfg_we, cfg_index, cfg_data
//
// Each request is held in an input register and resolved into the result
// register; the block accepts one request per clock while no result stalls.
// A result is valid once its request moves into the result register.
// Reset is asynchronous and clears the power state, counters and handshakes.
// A stalled result holds the pipeline; the input register refills as soon
// as the result register frees.

module link_loss_power_controller_top #(
    parameter int PAYLOAD_MAX = llpc_pkg::PAYLOAD_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    llpc_item_if.sink                       item,
    llpc_result_if.source                   result,
    input  logic                            cfg_we,
    input  logic [llpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [llpc_pkg::CFG_DATA_W-1:0] cfg_data
);

    llpc_pkg::cfg_t    cfg;
    llpc_pkg::result_t res;
    llpc_pkg::result_t res_reg;

    logic       in_valid_reg;
    logic       in_mode_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_charging_reg;
    logic       out_valid_reg;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    llpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    llpc_engine #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .fire         (advance),
        .mode         (in_mode_reg),
        .payload_byte (in_byte_reg),
        .last_byte    (in_last_reg),
        .charging     (in_charging_reg),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_mode_reg <= item.mode;
            in_byte_reg <= item.payload_byte;
            in_last_reg <= item.last_byte;
            in_charging_reg <= item.charging;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.action = res_reg.action;
    assign result.red_first = res_reg.red_first;
    assign result.green_first = res_reg.green_first;
    assign result.blue_first = res_reg.blue_first;
    assign result.red_second = res_reg.red_second;
    assign result.green_second = res_reg.green_second;
    assign result.blue_second = res_reg.blue_second;
    assign result.power_phase = res_reg.power_phase;

    // An orange or clear blink is only produced while the signal is lost.
    a_blink_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.action == llpc_pkg::ACT_ORANGE ||
                          res_reg.action == llpc_pkg::ACT_CLEAR)
        |-> res_reg.power_phase == llpc_pkg::PH_LOST)
        else $error("blink result outside signal lost phase");

    // A finished payload always leaves the link active.
    a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (res_reg.action == llpc_pkg::ACT_SHOW ||
                          res_reg.action == llpc_pkg::ACT_SHORT)
        |-> res_reg.power_phase == llpc_pkg::PH_ACTIVE)
        else $error("payload result without active phase");

    // A sleep request always reports the asleep phase.
    a_sleep_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.action == llpc_pkg::ACT_SLEEP
        |-> res_reg.power_phase == llpc_pkg::PH_SLEEP)
        else $error("sleep result without asleep phase");

    // A request moved out of the input register lands in the result register.
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed request lost between stages");

endmodule

FILE: verif/tb_link_loss_power_controller_top.sv
`timescale 1ns / 1ps

module tb_link_loss_power_controller_top;
    import llpc_pkg::*;

    localparam bit MODE_TICK = 1'b0;
    localparam bit MODE_BYTE = 1'b1;
    localparam int DIRECTED_ROWS = 27;
    localparam int RANDOM_TARGET = 1500;

    typedef struct packed {
        bit         mode;
        logic [7:0] data;
        bit         last;
        bit         charging;
    } request_t;

    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        bit                    mode;
        logic [7:0]            data;
        bit                    last;
        bit                    charging;
        bit                    typed;
        logic [2:0]            action;
        logic [1:0]            phase;
    } script_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    llpc_item_if item_bus ();
    llpc_result_if result_bus ();

    link_loss_power_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted controller state and its own copy of the settings.
    cfg_t        regs;
    logic [1:0]  phase_now;
    logic [19:0] phase_ms;
    logic [19:0] quiet_ms;
    logic [15:0] blink_ms;
    bit          blink_on;
    int          byte_pos;
    logic [7:0]  colors [6];

    result_t led_commands_due [$];
    bit      failed;
    bit      rush;
    bit      calm_tx;
    bit      calm_rx;
    int      stall_left;
    int      sent;

    always #6 clk = ~clk;

    function automatic int gap_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic request_t make_req(input bit mode, input logic [7:0] data,
                                          input bit last, input bit charging);
        request_t rq;
        rq.mode = mode;
        rq.data = data;
        rq.last = last;
        rq.charging = charging;
        return rq;
    endfunction

    function automatic result_t next_led_command(input request_t rq);
        result_t res;
        int base;
        res = '0;
        res.action = ACT_NONE;
        if (phase_now != PH_SLEEP) begin
            if (rq.mode == MODE_BYTE) begin
                base = regs.node_address * BYTES_PER_NODE;
                if (byte_pos < PAYLOAD_MAX_DEF) begin
                    if (byte_pos >= base && byte_pos < base + COLOR_SPAN)
                        colors[byte_pos - base] = rq.data;
                    byte_pos++;
                end
                if (rq.last) begin
                    if (byte_pos >= base + COLOR_SPAN) begin
                        res.action = ACT_SHOW;
                        res.red_first = colors[0];
                        res.green_first = colors[1];
                        res.blue_first = colors[2];
                        res.red_second = colors[3];
                        res.green_second = colors[4];
                        res.blue_second = colors[5];
                    end
                    else
                    begin
                        res.action = ACT_SHORT;
                    end
                    byte_pos = 0;
                    quiet_ms = '0;
                    if (phase_now != PH_ACTIVE)
                    begin
                        phase_now = PH_ACTIVE;
                        phase_ms = '0;
                    end
                end
            end
            else
            begin
                if (phase_ms != '1)
                    phase_ms++;
                if (quiet_ms != '1)
                    quiet_ms++;
                if (blink_ms != '1)
                    blink_ms++;
                if (!rq.charging) begin
                    case (phase_now)
                        PH_WAIT:
                        begin
                            if (phase_ms >= regs.startup_timeout_ms)
                            begin
                                phase_now = PH_SLEEP;
                                res.action = ACT_SLEEP;
                            end
                        end
                        PH_ACTIVE:
                        begin
                            if (quiet_ms >= regs.signal_lost_ms)
                            begin
                                phase_now = PH_LOST;
                                phase_ms = '0;
                                blink_ms = '0;
                                blink_on = 1'b0;
                            end
                        end
                        PH_LOST:
                        begin
                            if (phase_ms >= regs.lost_sleep_ms)
                            begin
                                phase_now = PH_SLEEP;
                                res.action = ACT_SLEEP;
                            end
                            else if (blink_ms >= regs.blink_half_ms)
                            begin
                                blink_ms = '0;
                                blink_on = !blink_on;
                                if (blink_on)
                                begin
                                    res.action = ACT_ORANGE;
                                    res.red_first = ORANGE_RED;
                                    res.green_first = ORANGE_GREEN;
                                    res.blue_first = ORANGE_BLUE;
                                    res.red_second = ORANGE_RED;
                                    res.green_second = ORANGE_GREEN;
                                    res.blue_second = ORANGE_BLUE;
                                end
                                else
                                begin
                                    res.action = ACT_CLEAR;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
        res.power_phase = phase_now;
        return res;
    endfunction

    // Sleep can only happen once per run, so a request that would cause it
    // early is turned into the end of a payload instead.
    function automatic request_t avoid_sleep(input request_t rq);
        logic [19:0] next_ms;
        next_ms = (phase_ms == '1) ? phase_ms : phase_ms + 20'd1;
        if (rq.mode == MODE_TICK && !rq.charging && phase_now == PH_LOST &&
            next_ms >= regs.lost_sleep_ms)
        begin
            rq.mode = MODE_BYTE;
            rq.last = 1'b1;
        end
        return rq;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_NODE_ADDRESS: regs.node_address = val[NODE_W-1:0];
            CFG_STARTUP_TIMEOUT: regs.startup_timeout_ms = val[LONG_W-1:0];
            CFG_SIGNAL_LOST: regs.signal_lost_ms = val[SHORT_W-1:0];
            CFG_LOST_SLEEP: regs.lost_sleep_ms = val[LONG_W-1:0];
            CFG_BLINK_HALF: regs.blink_half_ms = val[SHORT_W-1:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    task automatic send_request(input request_t rq, input bit typed = 1'b0,
                                input result_t fixed = '0);
        int idle;
        result_t want;
        idle = gap_len(calm_tx || rush);
        cfg_we <= 1'b0;
        if (idle > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.mode <= rq.mode;
        item_bus.payload_byte <= rq.data;
        item_bus.last_byte <= rq.last;
        item_bus.charging <= rq.charging;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        want = next_led_command(rq);
        if (typed)
            want = fixed;
        led_commands_due.push_back(want);
        sent++;
    endtask

    task automatic drain();
        item_bus.valid <= 1'b0;
        cfg_we <= 1'b0;
        do
            @(posedge clk);
        while (led_commands_due.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            result_bus.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            result_bus.ready <= 1'b1;
            stall_left <= gap_len(calm_rx || rush);
        end
        if ($urandom_range(0, 299) == 0)
            calm_rx <= ~calm_rx;
    end

    always @(posedge clk)
    begin : watch_results
        result_t seen;
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            seen.action = result_bus.action;
            seen.red_first = result_bus.red_first;
            seen.green_first = result_bus.green_first;
            seen.blue_first = result_bus.blue_first;
            seen.red_second = result_bus.red_second;
            seen.green_second = result_bus.green_second;
            seen.blue_second = result_bus.blue_second;
            seen.power_phase = result_bus.power_phase;
            if (led_commands_due.size() == 0)
            begin
                $display("%0t: unrequested result, expected none, actual action %0d",
                         $time, seen.action);
                failed = 1'b1;
            end
            else
            begin
                want = led_commands_due.pop_front();
                compare_field("action", want.action, seen.action);
                compare_field("red_first", want.red_first, seen.red_first);
                compare_field("green_first", want.green_first, seen.green_first);
                compare_field("blue_first", want.blue_first, seen.blue_first);
                compare_field("red_second", want.red_second, seen.red_second);
                compare_field("green_second", want.green_second, seen.green_second);
                compare_field("blue_second", want.blue_second, seen.blue_second);
                compare_field("power_phase", want.power_phase, seen.power_phase);
            end
        end
    end

    initial
    begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : stimulus
        script_row_t script [DIRECTED_ROWS];
        request_t rq;
        result_t fixed;
        int base;
        int len;
        int r;
        int count;
        int chg_sel;
        int phase_end;
        int random_start;

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_bus.valid = 1'b0;
        item_bus.mode = MODE_TICK;
        item_bus.payload_byte = '0;
        item_bus.last_byte = 1'b0;
        item_bus.charging = 1'b0;
        result_bus.ready = 1'b0;
        failed = 1'b0;
        rush = 1'b0;
        calm_tx = 1'b0;
        calm_rx = 1'b0;
        stall_left = 0;
        sent = 0;

        regs.node_address = NODE_ADDRESS_RST;
        regs.startup_timeout_ms = STARTUP_TIMEOUT_RST;
        regs.signal_lost_ms = SIGNAL_LOST_RST;
        regs.lost_sleep_ms = LOST_SLEEP_RST;
        regs.blink_half_ms = BLINK_HALF_RST;
        phase_now = PH_WAIT;
        phase_ms = '0;
        quiet_ms = '0;
        blink_ms = '0;
        blink_on = 1'b0;
        byte_pos = 0;
        foreach (colors[i])
            colors[i] = '0;

        script = '{
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b1, ACT_NONE, PH_WAIT},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_TICK, 8'h00, 1'b0, 1'b1, 1'b1, ACT_NONE, PH_WAIT},
            '{1'b1, CFG_STARTUP_TIMEOUT, 20'h1, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, ACT_NONE, PH_WAIT},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_TICK, 8'h00, 1'b0, 1'b1, 1'b1, ACT_NONE, PH_WAIT},
            '{1'b1, CFG_STARTUP_TIMEOUT, 20'hFFFFF, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, ACT_NONE,
              PH_WAIT},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b1, ACT_NONE, PH_WAIT},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_BYTE, 8'hFF, 1'b1, 1'b0, 1'b1, ACT_SHORT, PH_ACTIVE},
            '{1'b1, CFG_SIGNAL_LOST, 20'h1, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, ACT_NONE, PH_WAIT},
            '{1'b1, CFG_BLINK_HALF, 20'h1, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, ACT_NONE, PH_WAIT},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_TICK, 8'h00, 1'b0, 1'b1, 1'b1, ACT_NONE, PH_ACTIVE},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b1, ACT_NONE, PH_LOST},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b1, ACT_ORANGE, PH_LOST},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b1, ACT_CLEAR, PH_LOST},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_TICK, 8'h00, 1'b0, 1'b1, 1'b1, ACT_NONE, PH_LOST},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_BYTE, 8'h00, 1'b0, 1'b0, 1'b1, ACT_NONE, PH_LOST},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_BYTE, 8'hFF, 1'b0, 1'b0, 1'b1, ACT_NONE, PH_LOST},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_BYTE, 8'h01, 1'b0, 1'b1, 1'b1, ACT_NONE, PH_LOST},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_BYTE, 8'h80, 1'b0, 1'b0, 1'b1, ACT_NONE, PH_LOST},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_BYTE, 8'h7F, 1'b0, 1'b0, 1'b1, ACT_NONE, PH_LOST},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_BYTE, 8'hFE, 1'b1, 1'b0, 1'b0, ACT_NONE, PH_WAIT},
            '{1'b1, CFG_NODE_ADDRESS, 20'h1, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, ACT_NONE, PH_WAIT},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_BYTE, 8'h5A, 1'b0, 1'b1, 1'b1, ACT_NONE, PH_ACTIVE},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_BYTE, 8'hA5, 1'b1, 1'b0, 1'b1, ACT_SHORT, PH_ACTIVE},
            '{1'b1, CFG_SIGNAL_LOST, 20'hFFFF, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, ACT_NONE, PH_WAIT},
            '{1'b1, CFG_BLINK_HALF, 20'hFFFF, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, ACT_NONE, PH_WAIT},
            '{1'b1, CFG_LOST_SLEEP, 20'hFFFFF, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0, ACT_NONE, PH_WAIT},
            '{1'b0, CFG_NODE_ADDRESS, 20'h0, MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b1, ACT_NONE, PH_ACTIVE}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (script[i].is_cfg)
            begin
                drain();
                write_setting(script[i].reg_index, script[i].reg_value);
            end
            else
            begin
                fixed = '0;
                fixed.action = script[i].action;
                fixed.power_phase = script[i].phase;
                if (script[i].action == ACT_ORANGE)
                begin
                    fixed.red_first = ORANGE_RED;
                    fixed.green_first = ORANGE_GREEN;
                    fixed.blue_first = ORANGE_BLUE;
                    fixed.red_second = ORANGE_RED;
                    fixed.green_second = ORANGE_GREEN;
                    fixed.blue_second = ORANGE_BLUE;
                end
                send_request(make_req(script[i].mode, script[i].data, script[i].last,
                                      script[i].charging), script[i].typed, fixed);
            end
        end

        // Each round closes any open payload, settles, and then retunes
        // the controller before a new burst of requests.
        random_start = sent;
        while (sent < random_start + RANDOM_TARGET)
        begin
            if (byte_pos != 0)
                send_request(make_req(MODE_BYTE, $urandom_range(0, 255), 1'b1,
                                      $urandom_range(0, 1)));
            drain();
            r = $urandom_range(0, 99);
            write_setting(CFG_NODE_ADDRESS, r < 10 ? 15 : r < 20 ? 9 :
                          r < 60 ? $urandom_range(0, 2) : $urandom_range(0, 15));
            r = $urandom_range(0, 99);
            write_setting(CFG_SIGNAL_LOST, r < 10 ? 0 : r < 15 ? 20'hFFFF :
                          r < 80 ? $urandom_range(1, 30) : $urandom_range(1, 65535));
            r = $urandom_range(0, 99);
            write_setting(CFG_BLINK_HALF, r < 10 ? 0 : r < 15 ? 20'hFFFF :
                          r < 85 ? $urandom_range(1, 8) : $urandom_range(1, 65535));
            r = $urandom_range(0, 99);
            write_setting(CFG_LOST_SLEEP, r < 20 ? 20'hFFFFF :
                          r < 70 ? $urandom_range(5, 200) : $urandom_range(1, 20'hFFFFF));
            write_setting(CFG_STARTUP_TIMEOUT, $urandom_range(0, 20'hFFFFF));
            calm_tx = ($urandom_range(0, 4) == 0);
            phase_end = sent + $urandom_range(60, 200);
            while (sent < phase_end)
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    base = regs.node_address * BYTES_PER_NODE;
                    r = $urandom_range(0, 99);
                    if (r < 65)
                        len = base + COLOR_SPAN + $urandom_range(0, 4);
                    else if (r < 80)
                        len = $urandom_range(1, base + COLOR_SPAN - 1);
                    else if (r < 92)
                        len = base + COLOR_SPAN - $urandom_range(0, 1);
                    else if (r < 97)
                        len = $urandom_range(PAYLOAD_MAX_DEF - 2, PAYLOAD_MAX_DEF + 2);
                    else
                        len = $urandom_range(PAYLOAD_MAX_DEF + 3, PAYLOAD_MAX_DEF + 40);
                    for (int i = 0; i < len; i++)
                        send_request(make_req(MODE_BYTE, $urandom_range(0, 255), i == len - 1,
                                              $urandom_range(0, 1)));
                end
                else if (r < 90)
                begin
                    count = $urandom_range(1, 40);
                    chg_sel = $urandom_range(0, 19);
                    for (int i = 0; i < count; i++)
                    begin
                        rq = make_req(MODE_TICK, $urandom_range(0, 255), $urandom_range(0, 1),
                                      chg_sel < 3 ? 1 : chg_sel < 6 ? $urandom_range(0, 1) : 0);
                        send_request(avoid_sleep(rq));
                    end
                end
                else
                begin
                    count = $urandom_range(1, 6);
                    for (int i = 0; i < count; i++)
                        send_request(avoid_sleep(make_req($urandom_range(0, 1),
                                                          $urandom_range(0, 255),
                                                          $urandom_range(0, 1),
                                                          $urandom_range(0, 1))));
                end
            end
        end

        drain();
        calm_tx = 1'b0;
        write_setting(CFG_LOST_SLEEP, 20'h1);
        write_setting(CFG_SIGNAL_LOST, 20'h1);
        while (phase_now != PH_SLEEP)
            send_request(make_req(MODE_TICK, $urandom_range(0, 255), 1'b0, 1'b0));
        repeat (8)
            send_request(make_req($urandom_range(0, 1), $urandom_range(0, 255),
                                  $urandom_range(0, 1), $urandom_range(0, 1)));

        drain();
        repeat (4) @(posedge clk);
        if (!failed && led_commands_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
src/llpc_pkg.sv
src/llpc_item_if.sv
src/llpc_result_if.sv
src/llpc_cfg.sv
src/llpc_engine.sv
src/link_loss_power_controller_top.sv
verif/tb_link_loss_power_controller_top.sv
